>>> src/asd_pkg.sv
// Package with widths, register codes and sideband types of the arm swivel direction core.
package asd_pkg;

	localparam int unsigned CoordW  = 32;   // input coordinate, Q16.16
	localparam int unsigned DiffW   = 33;   // joint difference, Q16.16
	localparam int unsigned MagW    = 32;   // magnitude of a difference
	localparam int unsigned SqW     = 64;   // square of a difference
	localparam int unsigned SumAW   = 66;   // axis sum of squares
	localparam int unsigned LenW    = 33;   // axis length
	localparam int unsigned QuoW    = 17;   // quotient magnitude, Q1.16
	localparam int unsigned UnitW   = 18;   // signed unit component, Q1.16
	localparam int unsigned NumAW   = 48;   // axis dividend
	localparam int unsigned DotW    = 51;   // product and dot sum, Q16.32
	localparam int unsigned ProjW   = 35;   // projection length, Q16.16
	localparam int unsigned MprodW  = 52;   // axis component times projection
	localparam int unsigned RadW    = 37;   // radial component, Q16.16
	localparam int unsigned RmagW   = 36;   // radial magnitude
	localparam int unsigned HalfW   = 18;   // half of a radial magnitude
	localparam int unsigned PartW   = 36;   // partial product of halves
	localparam int unsigned RsqW    = 72;   // radial square
	localparam int unsigned SumBW   = 74;   // radial sum of squares
	localparam int unsigned RlenW   = 37;   // radial length
	localparam int unsigned NumBW   = 52;   // radial dividend
	localparam int unsigned MinW    = 16;   // threshold registers
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned FracW   = 16;

	localparam logic [MinW-1:0] AXIS_MIN_RESET   = 16'd0;
	localparam logic [MinW-1:0] RADIAL_MIN_RESET = 16'd66;
	localparam logic [FracW-1:0] TRUNC_BIAS      = 16'hFFFF;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_AXIS_MIN   = 1'b0,
		CFG_RADIAL_MIN = 1'b1
	} cfg_reg_t;

	// Carried alongside the axis square root.
	typedef struct packed {
		logic                    sk;
		logic signed [DiffW-1:0] dx;
		logic signed [DiffW-1:0] dy;
		logic signed [DiffW-1:0] dz;
		logic signed [DiffW-1:0] ex;
		logic signed [DiffW-1:0] ey;
		logic signed [DiffW-1:0] ez;
	} axis_tag_t;

	// Carried alongside the axis divider.
	typedef struct packed {
		logic                    ok;
		logic signed [DiffW-1:0] ex;
		logic signed [DiffW-1:0] ey;
		logic signed [DiffW-1:0] ez;
		logic                    neg;
	} qa_tag_t;

	// Carried alongside the radial square root.
	typedef struct packed {
		logic                    ok;
		logic [RmagW-1:0]        rmx;
		logic [RmagW-1:0]        rmy;
		logic [RmagW-1:0]        rmz;
		logic                    nx;
		logic                    ny;
		logic                    nz;
		logic signed [UnitW-1:0] ax;
		logic signed [UnitW-1:0] ay;
		logic signed [UnitW-1:0] az;
	} rad_tag_t;

	// Carried alongside the radial divider.
	typedef struct packed {
		logic                    ok;
		logic signed [UnitW-1:0] ax;
		logic signed [UnitW-1:0] ay;
		logic signed [UnitW-1:0] az;
		logic                    neg;
	} qb_tag_t;

endpackage

>>> src/asd_if.sv
// Handshake interfaces for joint words and result words.
interface asd_joint_if;
	logic                                valid;
	logic                                ready;
	logic                                skeleton_valid;
	logic signed [asd_pkg::CoordW-1:0]   shoulder_x;
	logic signed [asd_pkg::CoordW-1:0]   shoulder_y;
	logic signed [asd_pkg::CoordW-1:0]   shoulder_z;
	logic signed [asd_pkg::CoordW-1:0]   elbow_x;
	logic signed [asd_pkg::CoordW-1:0]   elbow_y;
	logic signed [asd_pkg::CoordW-1:0]   elbow_z;
	logic signed [asd_pkg::CoordW-1:0]   wrist_x;
	logic signed [asd_pkg::CoordW-1:0]   wrist_y;
	logic signed [asd_pkg::CoordW-1:0]   wrist_z;

	modport source (output valid, skeleton_valid, shoulder_x, shoulder_y, shoulder_z,
		elbow_x, elbow_y, elbow_z, wrist_x, wrist_y, wrist_z, input ready);
	modport sink (input valid, skeleton_valid, shoulder_x, shoulder_y, shoulder_z,
		elbow_x, elbow_y, elbow_z, wrist_x, wrist_y, wrist_z, output ready);
endinterface

interface asd_result_if;
	logic                              valid;
	logic                              ready;
	logic                              result_valid;
	logic signed [asd_pkg::UnitW-1:0]  dir_x;
	logic signed [asd_pkg::UnitW-1:0]  dir_y;
	logic signed [asd_pkg::UnitW-1:0]  dir_z;
	logic signed [asd_pkg::UnitW-1:0]  axis_x;
	logic signed [asd_pkg::UnitW-1:0]  axis_y;
	logic signed [asd_pkg::UnitW-1:0]  axis_z;

	modport source (output valid, result_valid, dir_x, dir_y, dir_z,
		axis_x, axis_y, axis_z, input ready);
	modport sink (input valid, result_valid, dir_x, dir_y, dir_z,
		axis_x, axis_y, axis_z, output ready);
endinterface

>>> src/asd_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
module asd_sqrt #(
	parameter int unsigned RootW = asd_pkg::LenW,
	parameter int unsigned TagW  = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2*RootW-1:0]   radicand,
	input  logic [TagW-1:0]      tag_in,
	output logic                 out_valid,
	output logic [RootW-1:0]     root,
	output logic [TagW-1:0]      tag_out
);
	localparam int unsigned RemW = RootW + 2;

	logic                 v_sk    [RootW];
	logic [RemW-1:0]      rem_sk  [RootW];
	logic [RootW-1:0]     root_sk [RootW];
	logic [2*RootW-1:0]   rad_sk  [RootW];
	logic [TagW-1:0]      tag_sk  [RootW];

	logic [RemW-1:0]      rem_nx  [RootW];
	logic [RootW-1:0]     root_nx [RootW];
	logic [2*RootW-1:0]   rad_nx  [RootW];

	always_comb begin
		logic [RemW-1:0]    rem_i;
		logic [RemW-1:0]    shifted;
		logic [RemW-1:0]    trial;
		logic [RootW-1:0]   root_i;
		logic [2*RootW-1:0] rad_i;
		for (int k = 0; k < RootW; k++) begin
			if (k == 0) begin
				rem_i  = '0;
				root_i = '0;
				rad_i  = radicand;
			end else begin
				rem_i  = rem_sk[k-1];
				root_i = root_sk[k-1];
				rad_i  = rad_sk[k-1];
			end
			// The partial remainder never exceeds twice the partial root.
			shifted = {rem_i[RootW-1:0], rad_i[2*RootW-1 -: 2]};
			trial   = {root_i, 2'b01};
			if (shifted >= trial) begin
				rem_nx[k]  = shifted - trial;
				root_nx[k] = {root_i[RootW-2:0], 1'b1};
			end else begin
				rem_nx[k]  = shifted;
				root_nx[k] = {root_i[RootW-2:0], 1'b0};
			end
			rad_nx[k] = rad_i << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RootW; k++) v_sk[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < RootW; k++) v_sk[k] <= (k == 0) ? in_valid : v_sk[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RootW; k++) begin
				rem_sk[k]  <= rem_nx[k];
				root_sk[k] <= root_nx[k];
				rad_sk[k]  <= rad_nx[k];
				tag_sk[k]  <= (k == 0) ? tag_in : tag_sk[k-1];
			end
		end
	end

	assign out_valid = v_sk[RootW-1];
	assign root      = root_sk[RootW-1];
	assign tag_out   = tag_sk[RootW-1];
endmodule

>>> src/asd_div.sv
// Pipelined restoring divider, one quotient bit per stage, for quotients known to fit.
module asd_div #(
	parameter int unsigned NumW = asd_pkg::NumAW,
	parameter int unsigned DenW = asd_pkg::LenW,
	parameter int unsigned QW   = asd_pkg::QuoW,
	parameter int unsigned TagW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NumW-1:0]   dividend,
	input  logic [DenW-1:0]   divisor,
	input  logic [TagW-1:0]   tag_in,
	output logic              out_valid,
	output logic [QW-1:0]     quotient,
	output logic [TagW-1:0]   tag_out
);
	localparam int unsigned HiW = NumW - QW;

	logic              v_sk   [QW];
	logic [DenW-1:0]   rem_sk [QW];
	logic [QW-1:0]     lo_sk  [QW];
	logic [QW-1:0]     quo_sk [QW];
	logic [DenW-1:0]   den_sk [QW];
	logic [TagW-1:0]   tag_sk [QW];

	logic [DenW-1:0]   rem_nx [QW];
	logic [QW-1:0]     lo_nx  [QW];
	logic [QW-1:0]     quo_nx [QW];

	always_comb begin
		logic [DenW-1:0] rem_i;
		logic [DenW-1:0] den_i;
		logic [QW-1:0]   lo_i;
		logic [QW-1:0]   quo_i;
		logic [DenW:0]   shifted;
		logic [DenW:0]   diff;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				// The upper dividend bits sit below the divisor when the quotient fits.
				rem_i = {{(DenW-HiW){1'b0}}, dividend[NumW-1:QW]};
				den_i = divisor;
				lo_i  = dividend[QW-1:0];
				quo_i = '0;
			end else begin
				rem_i = rem_sk[k-1];
				den_i = den_sk[k-1];
				lo_i  = lo_sk[k-1];
				quo_i = quo_sk[k-1];
			end
			shifted = {rem_i, lo_i[QW-1]};
			diff    = shifted - {1'b0, den_i};
			if (shifted >= {1'b0, den_i}) begin
				rem_nx[k] = diff[DenW-1:0];
				quo_nx[k] = {quo_i[QW-2:0], 1'b1};
			end else begin
				rem_nx[k] = shifted[DenW-1:0];
				quo_nx[k] = {quo_i[QW-2:0], 1'b0};
			end
			lo_nx[k] = lo_i << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) v_sk[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < QW; k++) v_sk[k] <= (k == 0) ? in_valid : v_sk[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_sk[k] <= rem_nx[k];
				lo_sk[k]  <= lo_nx[k];
				quo_sk[k] <= quo_nx[k];
				den_sk[k] <= (k == 0) ? divisor : den_sk[k-1];
				tag_sk[k] <= (k == 0) ? tag_in : tag_sk[k-1];
			end
		end
	end

	assign out_valid = v_sk[QW-1];
	assign quotient  = quo_sk[QW-1];
	assign tag_out   = tag_sk[QW-1];
endmodule

>>> src/arm_swivel_direction_core.sv
// Top level of the elbow swivel-plane direction pipeline.
//
//  channel   | dir | word
//  ----------+-----+-----------------------------------------------------
//  joints    | in  | skeleton flag, shoulder, elbow, wrist (Q16.16)
//  result    | out | valid flag, unit direction and unit axis (Q1.16)
//  cfg       | in  | write enable, index, 16-bit threshold data
//
// One word enters per cycle while the output register is not stalled; the two
// square roots take 33 and 37 stages, the two dividers 17 stages each, and
// 13 arithmetic stages plus the output register surround them.
// Reset clears every valid bit and loads the thresholds; no clearing pass.
// When the output register holds a word that is not taken, the whole
// pipeline holds and joints.ready drops; nothing is lost or repeated.
module arm_swivel_direction_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [asd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [asd_pkg::MinW-1:0]      cfg_data,
	asd_joint_if.sink                     joints,
	asd_result_if.source                  result
);
	localparam int unsigned DiffW  = asd_pkg::DiffW;
	localparam int unsigned MagW   = asd_pkg::MagW;
	localparam int unsigned SqW    = asd_pkg::SqW;
	localparam int unsigned SumAW  = asd_pkg::SumAW;
	localparam int unsigned LenW   = asd_pkg::LenW;
	localparam int unsigned QuoW   = asd_pkg::QuoW;
	localparam int unsigned UnitW  = asd_pkg::UnitW;
	localparam int unsigned NumAW  = asd_pkg::NumAW;
	localparam int unsigned DotW   = asd_pkg::DotW;
	localparam int unsigned ProjW  = asd_pkg::ProjW;
	localparam int unsigned MprodW = asd_pkg::MprodW;
	localparam int unsigned RadW   = asd_pkg::RadW;
	localparam int unsigned RmagW  = asd_pkg::RmagW;
	localparam int unsigned HalfW  = asd_pkg::HalfW;
	localparam int unsigned PartW  = asd_pkg::PartW;
	localparam int unsigned RsqW   = asd_pkg::RsqW;
	localparam int unsigned SumBW  = asd_pkg::SumBW;
	localparam int unsigned RlenW  = asd_pkg::RlenW;
	localparam int unsigned NumBW  = asd_pkg::NumBW;
	localparam int unsigned FracW  = asd_pkg::FracW;

	function automatic logic signed [DiffW-1:0] diff33(
		input logic signed [asd_pkg::CoordW-1:0] a,
		input logic signed [asd_pkg::CoordW-1:0] b
	);
		return DiffW'(a) - DiffW'(b);
	endfunction

	function automatic logic [DiffW-1:0] abs33(input logic signed [DiffW-1:0] x);
		return x[DiffW-1] ? DiffW'(-x) : DiffW'(x);
	endfunction

	function automatic logic [RadW-1:0] abs37(input logic signed [RadW-1:0] x);
		return x[RadW-1] ? RadW'(-x) : RadW'(x);
	endfunction

	logic                  adv;
	logic [asd_pkg::MinW-1:0] amin_q, rmin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amin_q <= asd_pkg::AXIS_MIN_RESET;
			rmin_q <= asd_pkg::RADIAL_MIN_RESET;
		end else if (cfg_we) begin
			case (asd_pkg::cfg_reg_t'(cfg_index))
				asd_pkg::CFG_AXIS_MIN:   amin_q <= cfg_data;
				asd_pkg::CFG_RADIAL_MIN: rmin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage registers.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic out_valid_q;

	logic                     sk_s1;
	logic signed [DiffW-1:0]  dx_s1, dy_s1, dz_s1, ex_s1, ey_s1, ez_s1;

	asd_pkg::axis_tag_t       tag_s2, tag_s3;
	logic [SqW-1:0]           sqx_s2, sqy_s2, sqz_s2;
	logic [SumAW-1:0]         sum_s3;

	logic                     va_sq;
	logic [LenW-1:0]          len_sq;
	logic [$bits(asd_pkg::axis_tag_t)-1:0] tag_sq_v;
	asd_pkg::axis_tag_t       tag_sq;

	logic                     ok_s4;
	logic [LenW-1:0]          len_s4;
	logic [NumAW-1:0]         numx_s4, numy_s4, numz_s4;
	logic                     nx_s4, ny_s4, nz_s4;
	logic signed [DiffW-1:0]  ex_s4, ey_s4, ez_s4;

	logic                     vax, vay, vaz;
	logic [QuoW-1:0]          qax, qay, qaz;
	logic [$bits(asd_pkg::qa_tag_t)-1:0] qa_tag_v;
	asd_pkg::qa_tag_t         qa_tag;
	logic                     qa_ny, qa_nz;

	logic                     ok_s5, ok_s6, ok_s7, ok_s8, ok_s9, ok_s10, ok_s11, ok_s12;
	logic signed [UnitW-1:0]  ax_s5, ay_s5, az_s5, ax_s6, ay_s6, az_s6, ax_s7, ay_s7, az_s7;
	logic signed [UnitW-1:0]  ax_s8, ay_s8, az_s8, ax_s9, ay_s9, az_s9;
	logic signed [UnitW-1:0]  ax_s10, ay_s10, az_s10, ax_s11, ay_s11, az_s11;
	logic signed [UnitW-1:0]  ax_s12, ay_s12, az_s12;
	logic signed [DiffW-1:0]  ex_s5, ey_s5, ez_s5, ex_s6, ey_s6, ez_s6;
	logic signed [DiffW-1:0]  ex_s7, ey_s7, ez_s7, ex_s8, ey_s8, ez_s8;
	logic signed [DotW-1:0]   px_s6, py_s6, pz_s6;
	logic signed [ProjW-1:0]  p_s7;
	logic signed [MprodW-1:0] mx_s8, my_s8, mz_s8;
	logic signed [RadW-1:0]   rx_s9, ry_s9, rz_s9;
	logic [RmagW-1:0]         rmx_s10, rmy_s10, rmz_s10, rmx_s11, rmy_s11, rmz_s11;
	logic [RmagW-1:0]         rmx_s12, rmy_s12, rmz_s12;
	logic                     nx_s10, ny_s10, nz_s10, nx_s11, ny_s11, nz_s11;
	logic                     nx_s12, ny_s12, nz_s12;
	logic [PartW-1:0]         hhx_s10, hlx_s10, llx_s10, hhy_s10, hly_s10, lly_s10;
	logic [PartW-1:0]         hhz_s10, hlz_s10, llz_s10;
	logic [RsqW-1:0]          sqx_s11, sqy_s11, sqz_s11;
	logic [SumBW-1:0]         sum_s12;

	logic                     vr_sq;
	logic [RlenW-1:0]         rlen_sq;
	logic [$bits(asd_pkg::rad_tag_t)-1:0] rad_tag_v;
	asd_pkg::rad_tag_t        rad_tag, rad_tag_s12;

	logic                     ok_s13;
	logic [RlenW-1:0]         rlen_s13;
	logic [NumBW-1:0]         numx_s13, numy_s13, numz_s13;
	logic                     nx_s13, ny_s13, nz_s13;
	logic signed [UnitW-1:0]  ax_s13, ay_s13, az_s13;

	logic                     vbx, vby, vbz;
	logic [QuoW-1:0]          qbx, qby, qbz;
	logic [$bits(asd_pkg::qb_tag_t)-1:0] qb_tag_v;
	asd_pkg::qb_tag_t         qb_tag, qb_tag_s13;
	logic                     qb_ny, qb_nz;

	logic                     res_ok_q;
	logic signed [UnitW-1:0]  dirx_q, diry_q, dirz_q, axx_q, axy_q, axz_q;

	// Combinational helpers.
	logic [DiffW-1:0]         mdx, mdy, mdz;
	logic [MagW-1:0]          mdx32, mdy32, mdz32;
	logic [DiffW-1:0]         mlx, mly, mlz;
	logic signed [DotW-1:0]   dot_c, dotr_c;
	logic signed [MprodW-1:0] mxr_c, myr_c, mzr_c;
	logic [RadW-1:0]          rax, ray, raz;
	logic [RmagW-1:0]         rmx_c, rmy_c, rmz_c;
	asd_pkg::axis_tag_t       tag_s1_c;

	assign adv          = !out_valid_q || result.ready;
	assign joints.ready = adv;

	always_comb begin
		tag_s1_c.sk = sk_s1;
		tag_s1_c.dx = dx_s1;
		tag_s1_c.dy = dy_s1;
		tag_s1_c.dz = dz_s1;
		tag_s1_c.ex = ex_s1;
		tag_s1_c.ey = ey_s1;
		tag_s1_c.ez = ez_s1;
		mdx   = abs33(dx_s1);
		mdy   = abs33(dy_s1);
		mdz   = abs33(dz_s1);
		mdx32 = mdx[MagW-1:0];
		mdy32 = mdy[MagW-1:0];
		mdz32 = mdz[MagW-1:0];
		mlx   = abs33(tag_sq.dx);
		mly   = abs33(tag_sq.dy);
		mlz   = abs33(tag_sq.dz);
		// Truncation toward zero: bias negative values before the shift.
		dot_c  = px_s6 + py_s6 + pz_s6;
		dotr_c = dot_c + (dot_c[DotW-1] ? DotW'(asd_pkg::TRUNC_BIAS) : DotW'(0));
		mxr_c  = mx_s8 + (mx_s8[MprodW-1] ? MprodW'(asd_pkg::TRUNC_BIAS) : MprodW'(0));
		myr_c  = my_s8 + (my_s8[MprodW-1] ? MprodW'(asd_pkg::TRUNC_BIAS) : MprodW'(0));
		mzr_c  = mz_s8 + (mz_s8[MprodW-1] ? MprodW'(asd_pkg::TRUNC_BIAS) : MprodW'(0));
		rax    = abs37(rx_s9);
		ray    = abs37(ry_s9);
		raz    = abs37(rz_s9);
		rmx_c  = rax[RmagW-1:0];
		rmy_c  = ray[RmagW-1:0];
		rmz_c  = raz[RmagW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1  <= joints.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= va_sq;
			v_s5  <= vax & vay & vaz;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= vr_sq;
			out_valid_q <= vbx & vby & vbz;
		end
	end

	// Front end: differences, squares, sum.
	always_ff @(posedge clk) begin
		if (adv) begin
			sk_s1  <= joints.skeleton_valid;
			dx_s1  <= diff33(joints.wrist_x, joints.shoulder_x);
			dy_s1  <= diff33(joints.wrist_y, joints.shoulder_y);
			dz_s1  <= diff33(joints.wrist_z, joints.shoulder_z);
			ex_s1  <= diff33(joints.elbow_x, joints.shoulder_x);
			ey_s1  <= diff33(joints.elbow_y, joints.shoulder_y);
			ez_s1  <= diff33(joints.elbow_z, joints.shoulder_z);

			tag_s2 <= tag_s1_c;
			sqx_s2 <= SqW'(mdx32) * SqW'(mdx32);
			sqy_s2 <= SqW'(mdy32) * SqW'(mdy32);
			sqz_s2 <= SqW'(mdz32) * SqW'(mdz32);

			tag_s3 <= tag_s2;
			sum_s3 <= SumAW'(sqx_s2) + SumAW'(sqy_s2) + SumAW'(sqz_s2);
		end
	end

	asd_sqrt #(.RootW(LenW), .TagW($bits(asd_pkg::axis_tag_t))) u_sqrt_axis (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s3), .radicand(sum_s3), .tag_in(tag_s3),
		.out_valid(va_sq), .root(len_sq), .tag_out(tag_sq_v)
	);
	assign tag_sq = asd_pkg::axis_tag_t'(tag_sq_v);

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s4   <= tag_sq.sk && (len_sq > LenW'(amin_q));
			len_s4  <= len_sq;
			numx_s4 <= {mlx[MagW-1:0], {FracW{1'b0}}};
			numy_s4 <= {mly[MagW-1:0], {FracW{1'b0}}};
			numz_s4 <= {mlz[MagW-1:0], {FracW{1'b0}}};
			nx_s4   <= tag_sq.dx[DiffW-1];
			ny_s4   <= tag_sq.dy[DiffW-1];
			nz_s4   <= tag_sq.dz[DiffW-1];
			ex_s4   <= tag_sq.ex;
			ey_s4   <= tag_sq.ey;
			ez_s4   <= tag_sq.ez;
		end
	end

	asd_div #(.NumW(NumAW), .DenW(LenW), .QW(QuoW), .TagW($bits(asd_pkg::qa_tag_t)))
	u_div_ax (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s4),
		.dividend(numx_s4), .divisor(len_s4),
		.tag_in({ok_s4, ex_s4, ey_s4, ez_s4, nx_s4}),
		.out_valid(vax), .quotient(qax), .tag_out(qa_tag_v)
	);
	asd_div #(.NumW(NumAW), .DenW(LenW), .QW(QuoW), .TagW(1)) u_div_ay (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s4),
		.dividend(numy_s4), .divisor(len_s4), .tag_in(ny_s4),
		.out_valid(vay), .quotient(qay), .tag_out(qa_ny)
	);
	asd_div #(.NumW(NumAW), .DenW(LenW), .QW(QuoW), .TagW(1)) u_div_az (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s4),
		.dividend(numz_s4), .divisor(len_s4), .tag_in(nz_s4),
		.out_valid(vaz), .quotient(qaz), .tag_out(qa_nz)
	);
	assign qa_tag = asd_pkg::qa_tag_t'(qa_tag_v);

	// Middle: axis, dot product, projection, radial vector, its squares and their sum.
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s5 <= qa_tag.ok;
			ax_s5 <= qa_tag.neg ? -UnitW'(qax) : UnitW'(qax);
			ay_s5 <= qa_ny ? -UnitW'(qay) : UnitW'(qay);
			az_s5 <= qa_nz ? -UnitW'(qaz) : UnitW'(qaz);
			ex_s5 <= qa_tag.ex;
			ey_s5 <= qa_tag.ey;
			ez_s5 <= qa_tag.ez;

			ok_s6 <= ok_s5;
			ax_s6 <= ax_s5; ay_s6 <= ay_s5; az_s6 <= az_s5;
			ex_s6 <= ex_s5; ey_s6 <= ey_s5; ez_s6 <= ez_s5;
			px_s6 <= DotW'(ax_s5) * DotW'(ex_s5);
			py_s6 <= DotW'(ay_s5) * DotW'(ey_s5);
			pz_s6 <= DotW'(az_s5) * DotW'(ez_s5);

			ok_s7 <= ok_s6;
			ax_s7 <= ax_s6; ay_s7 <= ay_s6; az_s7 <= az_s6;
			ex_s7 <= ex_s6; ey_s7 <= ey_s6; ez_s7 <= ez_s6;
			p_s7  <= ProjW'(dotr_c >>> FracW);

			ok_s8 <= ok_s7;
			ax_s8 <= ax_s7; ay_s8 <= ay_s7; az_s8 <= az_s7;
			ex_s8 <= ex_s7; ey_s8 <= ey_s7; ez_s8 <= ez_s7;
			mx_s8 <= MprodW'(ax_s7) * MprodW'(p_s7);
			my_s8 <= MprodW'(ay_s7) * MprodW'(p_s7);
			mz_s8 <= MprodW'(az_s7) * MprodW'(p_s7);

			ok_s9 <= ok_s8;
			ax_s9 <= ax_s8; ay_s9 <= ay_s8; az_s9 <= az_s8;
			rx_s9 <= RadW'(ex_s8) - RadW'(mxr_c >>> FracW);
			ry_s9 <= RadW'(ey_s8) - RadW'(myr_c >>> FracW);
			rz_s9 <= RadW'(ez_s8) - RadW'(mzr_c >>> FracW);

			// Radial squares are split into halves to keep each multiplier narrow.
			ok_s10  <= ok_s9;
			ax_s10  <= ax_s9; ay_s10 <= ay_s9; az_s10 <= az_s9;
			rmx_s10 <= rmx_c; rmy_s10 <= rmy_c; rmz_s10 <= rmz_c;
			nx_s10  <= rx_s9[RadW-1]; ny_s10 <= ry_s9[RadW-1]; nz_s10 <= rz_s9[RadW-1];
			hhx_s10 <= PartW'(rmx_c[RmagW-1:HalfW]) * PartW'(rmx_c[RmagW-1:HalfW]);
			hlx_s10 <= PartW'(rmx_c[RmagW-1:HalfW]) * PartW'(rmx_c[HalfW-1:0]);
			llx_s10 <= PartW'(rmx_c[HalfW-1:0]) * PartW'(rmx_c[HalfW-1:0]);
			hhy_s10 <= PartW'(rmy_c[RmagW-1:HalfW]) * PartW'(rmy_c[RmagW-1:HalfW]);
			hly_s10 <= PartW'(rmy_c[RmagW-1:HalfW]) * PartW'(rmy_c[HalfW-1:0]);
			lly_s10 <= PartW'(rmy_c[HalfW-1:0]) * PartW'(rmy_c[HalfW-1:0]);
			hhz_s10 <= PartW'(rmz_c[RmagW-1:HalfW]) * PartW'(rmz_c[RmagW-1:HalfW]);
			hlz_s10 <= PartW'(rmz_c[RmagW-1:HalfW]) * PartW'(rmz_c[HalfW-1:0]);
			llz_s10 <= PartW'(rmz_c[HalfW-1:0]) * PartW'(rmz_c[HalfW-1:0]);

			ok_s11  <= ok_s10;
			ax_s11  <= ax_s10; ay_s11 <= ay_s10; az_s11 <= az_s10;
			rmx_s11 <= rmx_s10; rmy_s11 <= rmy_s10; rmz_s11 <= rmz_s10;
			nx_s11  <= nx_s10; ny_s11 <= ny_s10; nz_s11 <= nz_s10;
			sqx_s11 <= (RsqW'(hhx_s10) << (2*HalfW)) + (RsqW'(hlx_s10) << (HalfW+1))
				+ RsqW'(llx_s10);
			sqy_s11 <= (RsqW'(hhy_s10) << (2*HalfW)) + (RsqW'(hly_s10) << (HalfW+1))
				+ RsqW'(lly_s10);
			sqz_s11 <= (RsqW'(hhz_s10) << (2*HalfW)) + (RsqW'(hlz_s10) << (HalfW+1))
				+ RsqW'(llz_s10);

			ok_s12  <= ok_s11;
			ax_s12  <= ax_s11; ay_s12 <= ay_s11; az_s12 <= az_s11;
			rmx_s12 <= rmx_s11; rmy_s12 <= rmy_s11; rmz_s12 <= rmz_s11;
			nx_s12  <= nx_s11; ny_s12 <= ny_s11; nz_s12 <= nz_s11;
			sum_s12 <= SumBW'(sqx_s11) + SumBW'(sqy_s11) + SumBW'(sqz_s11);
		end
	end

	always_comb begin
		rad_tag_s12.ok  = ok_s12;
		rad_tag_s12.rmx = rmx_s12;
		rad_tag_s12.rmy = rmy_s12;
		rad_tag_s12.rmz = rmz_s12;
		rad_tag_s12.nx  = nx_s12;
		rad_tag_s12.ny  = ny_s12;
		rad_tag_s12.nz  = nz_s12;
		rad_tag_s12.ax  = ax_s12;
		rad_tag_s12.ay  = ay_s12;
		rad_tag_s12.az  = az_s12;
	end

	asd_sqrt #(.RootW(RlenW), .TagW($bits(asd_pkg::rad_tag_t))) u_sqrt_rad (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s12), .radicand(sum_s12), .tag_in(rad_tag_s12),
		.out_valid(vr_sq), .root(rlen_sq), .tag_out(rad_tag_v)
	);
	assign rad_tag = asd_pkg::rad_tag_t'(rad_tag_v);

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s13   <= rad_tag.ok && (rlen_sq > RlenW'(rmin_q));
			rlen_s13 <= rlen_sq;
			numx_s13 <= {rad_tag.rmx, {FracW{1'b0}}};
			numy_s13 <= {rad_tag.rmy, {FracW{1'b0}}};
			numz_s13 <= {rad_tag.rmz, {FracW{1'b0}}};
			nx_s13   <= rad_tag.nx;
			ny_s13   <= rad_tag.ny;
			nz_s13   <= rad_tag.nz;
			ax_s13   <= rad_tag.ax;
			ay_s13   <= rad_tag.ay;
			az_s13   <= rad_tag.az;
		end
	end

	always_comb begin
		qb_tag_s13.ok  = ok_s13;
		qb_tag_s13.ax  = ax_s13;
		qb_tag_s13.ay  = ay_s13;
		qb_tag_s13.az  = az_s13;
		qb_tag_s13.neg = nx_s13;
	end

	asd_div #(.NumW(NumBW), .DenW(RlenW), .QW(QuoW), .TagW($bits(asd_pkg::qb_tag_t)))
	u_div_rx (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s13),
		.dividend(numx_s13), .divisor(rlen_s13), .tag_in(qb_tag_s13),
		.out_valid(vbx), .quotient(qbx), .tag_out(qb_tag_v)
	);
	asd_div #(.NumW(NumBW), .DenW(RlenW), .QW(QuoW), .TagW(1)) u_div_ry (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s13),
		.dividend(numy_s13), .divisor(rlen_s13), .tag_in(ny_s13),
		.out_valid(vby), .quotient(qby), .tag_out(qb_ny)
	);
	asd_div #(.NumW(NumBW), .DenW(RlenW), .QW(QuoW), .TagW(1)) u_div_rz (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s13),
		.dividend(numz_s13), .divisor(rlen_s13), .tag_in(nz_s13),
		.out_valid(vbz), .quotient(qbz), .tag_out(qb_nz)
	);
	assign qb_tag = asd_pkg::qb_tag_t'(qb_tag_v);

	// Output register; an invalid word carries all-zero vectors.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_ok_q <= qb_tag.ok;
			if (qb_tag.ok) begin
				dirx_q <= qb_tag.neg ? -UnitW'(qbx) : UnitW'(qbx);
				diry_q <= qb_ny ? -UnitW'(qby) : UnitW'(qby);
				dirz_q <= qb_nz ? -UnitW'(qbz) : UnitW'(qbz);
				axx_q  <= qb_tag.ax;
				axy_q  <= qb_tag.ay;
				axz_q  <= qb_tag.az;
			end else begin
				dirx_q <= '0; diry_q <= '0; dirz_q <= '0;
				axx_q  <= '0; axy_q  <= '0; axz_q  <= '0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_valid = res_ok_q;
	assign result.dir_x        = dirx_q;
	assign result.dir_y        = diry_q;
	assign result.dir_z        = dirz_q;
	assign result.axis_x       = axx_q;
	assign result.axis_y       = axy_q;
	assign result.axis_z       = axz_q;
endmodule

>>> src/asd_checker.sv
// Port-level assertions for the arm swivel direction core, bound to the top level.
module asd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              res_valid,
	input logic signed [asd_pkg::UnitW-1:0]  dir_x,
	input logic signed [asd_pkg::UnitW-1:0]  dir_y,
	input logic signed [asd_pkg::UnitW-1:0]  dir_z,
	input logic signed [asd_pkg::UnitW-1:0]  axis_x,
	input logic signed [asd_pkg::UnitW-1:0]  axis_y,
	input logic signed [asd_pkg::UnitW-1:0]  axis_z
);
	// The input side stalls exactly when a finished word is held.
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the output stall");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !res_valid) |-> (dir_x == 0 && dir_y == 0 && dir_z == 0 &&
		axis_x == 0 && axis_y == 0 && axis_z == 0))
		else $error("invalid result word carries nonzero vectors");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_valid) |-> (dir_x <= 65536 && dir_x >= -65536 &&
		axis_x <= 65536 && axis_x >= -65536))
		else $error("unit component out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(dir_x) && $stable(axis_z)
		&& $stable(res_valid)))
		else $error("stalled result word changed");

	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");
endmodule

bind arm_swivel_direction_core asd_checker u_asd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(joints.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.res_valid(result.result_valid),
	.dir_x(result.dir_x),
	.dir_y(result.dir_y),
	.dir_z(result.dir_z),
	.axis_x(result.axis_x),
	.axis_y(result.axis_y),
	.axis_z(result.axis_z)
);

>>> bench/asd_swivel_checker.sv
// Checker that mirrors the thresholds, predicts each swivel result and compares it.
module asd_swivel_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [asd_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [asd_pkg::MinW-1:0]    cfg_data,
	asd_joint_if                        joints,
	asd_result_if                       result,
	output int                          fails,
	output int                          pending,
	output int                          valid_seen,
	output int                          results_seen
);
	typedef struct packed {
		logic                             ok;
		logic signed [asd_pkg::UnitW-1:0] dx;
		logic signed [asd_pkg::UnitW-1:0] dy;
		logic signed [asd_pkg::UnitW-1:0] dz;
		logic signed [asd_pkg::UnitW-1:0] ax;
		logic signed [asd_pkg::UnitW-1:0] ay;
		logic signed [asd_pkg::UnitW-1:0] az;
	} swivel_t;

	logic [asd_pkg::MinW-1:0] axis_floor;
	logic [asd_pkg::MinW-1:0] radial_floor;
	swivel_t                  swivel_q[$];

	// Truncated square root of the exact sum of squares of three components.
	function automatic longint vec_length(input longint x, input longint y, input longint z);
		logic [127:0] mx, my, mz, s, c;
		logic [63:0]  r;
		mx = 128'(x < 0 ? -x : x);
		my = 128'(y < 0 ? -y : y);
		mz = 128'(z < 0 ? -z : z);
		s  = mx * mx + my * my + mz * mz;
		r  = '0;
		for (int b = 63; b >= 0; b--) begin
			c = 128'(r | (64'd1 << b));
			if (c * c <= s)
				r = c[63:0];
		end
		return longint'(r);
	endfunction

	function automatic swivel_t predict_swivel(input logic sk,
			input logic signed [asd_pkg::CoordW-1:0] sx, sy, sz, ex, ey, ez, wx, wy, wz);
		swivel_t      res;
		longint       d[3], e[3], a[3], r[3];
		longint       len, rlen, dot, proj;
		res = '0;
		if (!sk)
			return res;
		d[0] = longint'(wx) - longint'(sx);
		d[1] = longint'(wy) - longint'(sy);
		d[2] = longint'(wz) - longint'(sz);
		e[0] = longint'(ex) - longint'(sx);
		e[1] = longint'(ey) - longint'(sy);
		e[2] = longint'(ez) - longint'(sz);
		len = vec_length(d[0], d[1], d[2]);
		if (len <= longint'(axis_floor))
			return res;
		dot = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = (d[i] * 65536) / len;
			dot += a[i] * e[i];
		end
		proj = dot / 65536;
		for (int i = 0; i < 3; i++)
			r[i] = e[i] - (a[i] * proj) / 65536;
		rlen = vec_length(r[0], r[1], r[2]);
		if (rlen <= longint'(radial_floor))
			return res;
		res.ok = 1'b1;
		res.dx = asd_pkg::UnitW'((r[0] * 65536) / rlen);
		res.dy = asd_pkg::UnitW'((r[1] * 65536) / rlen);
		res.dz = asd_pkg::UnitW'((r[2] * 65536) / rlen);
		res.ax = asd_pkg::UnitW'(a[0]);
		res.ay = asd_pkg::UnitW'(a[1]);
		res.az = asd_pkg::UnitW'(a[2]);
		return res;
	endfunction

	task automatic check_field(input string name,
			input logic signed [asd_pkg::UnitW-1:0] want,
			input logic signed [asd_pkg::UnitW-1:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_floor   <= asd_pkg::AXIS_MIN_RESET;
			radial_floor <= asd_pkg::RADIAL_MIN_RESET;
		end else if (cfg_we) begin
			case (asd_pkg::cfg_reg_t'(cfg_index))
				asd_pkg::CFG_AXIS_MIN:   axis_floor   <= cfg_data;
				asd_pkg::CFG_RADIAL_MIN: radial_floor <= cfg_data;
				default: ;
			endcase
		end
	end

	initial begin
		fails        = 0;
		valid_seen   = 0;
		results_seen = 0;
	end

	always @(posedge clk) begin
		swivel_t want;
		if (arst_n && joints.valid && joints.ready)
			swivel_q.push_back(predict_swivel(joints.skeleton_valid,
				joints.shoulder_x, joints.shoulder_y, joints.shoulder_z,
				joints.elbow_x, joints.elbow_y, joints.elbow_z,
				joints.wrist_x, joints.wrist_y, joints.wrist_z));
		if (arst_n && result.valid && result.ready) begin
			results_seen++;
			if (swivel_q.size() == 0) begin
				fails++;
				$display("%0t: result word with nothing expected", $time);
			end else begin
				want = swivel_q.pop_front();
				if (want.ok)
					valid_seen++;
				if (want.ok !== result.result_valid) begin
					fails++;
					$display("%0t: result_valid mismatch, expected %0b, actual %0b",
						$time, want.ok, result.result_valid);
				end
				check_field("dir_x", want.dx, result.dir_x);
				check_field("dir_y", want.dy, result.dir_y);
				check_field("dir_z", want.dz, result.dir_z);
				check_field("axis_x", want.ax, result.axis_x);
				check_field("axis_y", want.ay, result.axis_y);
				check_field("axis_z", want.az, result.axis_z);
			end
		end
		// Taken after this edge's push and pop so the count is never stale.
		pending <= swivel_q.size();
	end

endmodule

>>> bench/tb_arm_swivel_direction_core.sv
// Testbench top: clock, reset, joint stimulus, result stalls, thresholds and verdict.
module tb_arm_swivel_direction_core;
	localparam int IdleLimit = 3000;
	localparam int Drain     = 200;

	typedef struct {
		logic                              sk;
		logic signed [asd_pkg::CoordW-1:0] s[3];
		logic signed [asd_pkg::CoordW-1:0] e[3];
		logic signed [asd_pkg::CoordW-1:0] w[3];
	} arm_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [asd_pkg::CfgIdxW-1:0]  cfg_index;
	logic [asd_pkg::MinW-1:0]     cfg_data;
	int                           fails, pending, valid_seen, results_seen;
	int                           idle_cycles;
	int                           sent;
	int                           out_wait;
	bit                           no_stall;

	asd_joint_if  joints ();
	asd_result_if result ();

	arm_swivel_direction_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.joints    (joints),
		.result    (result)
	);

	asd_swivel_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.joints       (joints),
		.result       (result),
		.fails        (fails),
		.pending      (pending),
		.valid_seen   (valid_seen),
		.results_seen (results_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result side stalls a random number of cycles, possibly none, after each word it takes, unless no_stall is set.
	always @(posedge clk) begin
		int n;
		if (!arst_n) begin
			result.ready <= 1'b1;
			out_wait     <= 0;
		end else if (result.valid && result.ready) begin
			n = no_stall ? 0 : $urandom_range(8);
			result.ready <= (n == 0);
			out_wait     <= n;
		end else if (!result.ready) begin
			if (out_wait <= 1)
				result.ready <= 1'b1;
			out_wait <= out_wait - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((joints.valid && joints.ready) || (result.valid && result.ready)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout after %0d cycles without a word moving", idle_cycles);
			$display("arm_swivel_direction_core regression: fail");
			$finish;
		end
	end

	task automatic send_arm(input arm_t arm);
		int gap;
		gap = no_stall ? 0 : $urandom_range(8);
		if (gap > 0) begin
			joints.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		joints.valid          <= 1'b1;
		joints.skeleton_valid <= arm.sk;
		joints.shoulder_x     <= arm.s[0];
		joints.shoulder_y     <= arm.s[1];
		joints.shoulder_z     <= arm.s[2];
		joints.elbow_x        <= arm.e[0];
		joints.elbow_y        <= arm.e[1];
		joints.elbow_z        <= arm.e[2];
		joints.wrist_x        <= arm.w[0];
		joints.wrist_y        <= arm.w[1];
		joints.wrist_z        <= arm.w[2];
		do
			@(posedge clk);
		while (!joints.ready);
		sent++;
	endtask

	task automatic wait_drained();
		joints.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// The enable drops for a cycle after each write, so back-to-back calls never
	// assign it twice in one step.
	task automatic write_reg(input asd_pkg::cfg_reg_t idx,
			input logic [asd_pkg::MinW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	function automatic arm_t make_arm(input logic sk,
			input int sx, sy, sz, ex, ey, ez, wx, wy, wz);
		arm_t a;
		a.sk = sk;
		a.s[0] = sx; a.s[1] = sy; a.s[2] = sz;
		a.e[0] = ex; a.e[1] = ey; a.e[2] = ez;
		a.w[0] = wx; a.w[1] = wy; a.w[2] = wz;
		return a;
	endfunction

	// Mostly plausible arm poses, with raw words, collinear elbows and short axes mixed in.
	function automatic arm_t random_arm();
		arm_t a;
		int   kind, span, k;
		kind = $urandom_range(99);
		a.sk = ($urandom_range(9) != 0);
		span = ($urandom_range(3) == 0) ? 32'h7fffff : 32'h1ffff;
		for (int i = 0; i < 3; i++) begin
			a.s[i] = $urandom_range(2 * span) - span;
			a.e[i] = a.s[i] + $urandom_range(60000) - 30000;
			a.w[i] = a.e[i] + $urandom_range(60000) - 30000;
		end
		if (kind < 15) begin
			for (int i = 0; i < 3; i++) begin
				a.s[i] = $urandom;
				a.e[i] = $urandom;
				a.w[i] = $urandom;
			end
		end else if (kind < 25) begin
			k = int'($urandom_range(4)) + 1;
			for (int i = 0; i < 3; i++)
				a.e[i] = a.s[i] + (a.w[i] - a.s[i]) / k + int'($urandom_range(4)) - 2;
		end else if (kind < 33) begin
			for (int i = 0; i < 3; i++)
				a.w[i] = a.s[i] + $urandom_range(400) - 200;
		end
		return a;
	endfunction

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++) begin
			no_stall <= ((n / 60) % 4 == 3);
			send_arm(random_arm());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = asd_pkg::CFG_AXIS_MIN;
		cfg_data     = '0;
		no_stall     = 1'b0;
		idle_cycles  = 0;
		sent         = 0;
		result.ready = 1'b1;
		joints.valid = 1'b0;
		joints.skeleton_valid = 1'b0;
		joints.shoulder_x = '0; joints.shoulder_y = '0; joints.shoulder_z = '0;
		joints.elbow_x    = '0; joints.elbow_y    = '0; joints.elbow_z    = '0;
		joints.wrist_x    = '0; joints.wrist_y    = '0; joints.wrist_z    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset thresholds.
		send_arm(make_arm(1, 0, 0, 0, 0, 65536, 0, 65536, 0, 0));
		send_arm(make_arm(0, 0, 0, 0, 0, 65536, 0, 65536, 0, 0));
		send_arm(make_arm(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_arm(make_arm(1, 5, 5, 5, 7, 9, 11, 5, 5, 5));
		send_arm(make_arm(1, 0, 0, 0, 0, 66, 0, 65536, 0, 0));
		send_arm(make_arm(1, 0, 0, 0, 0, 67, 0, 65536, 0, 0));
		send_arm(make_arm(1, 0, 0, 0, 32768, 0, 0, 65536, 0, 0));
		send_arm(make_arm(1, 0, 0, 0, 0, 0, -70000, 0, -65536, 0));
		send_arm(make_arm(1, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_arm(make_arm(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000));
		send_arm(make_arm(1, 32'h80000000, 0, 0, 0, 32'h7fffffff, 0,
			32'h7fffffff, 0, 0));
		send_arm(make_arm(1, -1, -1, -1, 20000, -30000, 10000, 40000, 25000, -35000));
		wait_drained();

		// Further threshold settings, including both limits, each after a pause for the pipeline to empty.
		repeat (Drain) @(posedge clk);
		write_reg(asd_pkg::CFG_AXIS_MIN, 16'd100);
		write_reg(asd_pkg::CFG_RADIAL_MIN, 16'd66);
		send_arm(make_arm(1, 0, 0, 0, 0, 5000, 0, 100, 0, 0));
		send_arm(make_arm(1, 0, 0, 0, 0, 5000, 0, 101, 0, 0));
		send_arm(make_arm(1, 0, 0, 0, 0, 0, 5000, 0, 0, -101));
		run_random(250);
		wait_drained();
		repeat (Drain) @(posedge clk);
		write_reg(asd_pkg::CFG_AXIS_MIN, 16'hffff);
		write_reg(asd_pkg::CFG_RADIAL_MIN, 16'hffff);
		send_arm(make_arm(1, 0, 0, 0, 0, 65535, 0, 65535, 0, 0));
		send_arm(make_arm(1, 0, 0, 0, 0, 65536, 0, 65536, 0, 0));
		run_random(250);
		wait_drained();
		repeat (Drain) @(posedge clk);
		write_reg(asd_pkg::CFG_AXIS_MIN, 16'd0);
		write_reg(asd_pkg::CFG_RADIAL_MIN, 16'd0);
		send_arm(make_arm(1, 0, 0, 0, 0, 1, 0, 1, 0, 0));
		send_arm(make_arm(1, 0, 0, 0, 1, 0, 0, 1, 0, 0));
		run_random(300);
		wait_drained();
		repeat (Drain) @(posedge clk);
		write_reg(asd_pkg::CFG_AXIS_MIN, 16'($urandom_range(2000)));
		write_reg(asd_pkg::CFG_RADIAL_MIN, 16'($urandom_range(65535)));
		run_random(150);
		wait_drained();
		repeat (Drain) @(posedge clk);
		write_reg(asd_pkg::CFG_AXIS_MIN, asd_pkg::AXIS_MIN_RESET);
		write_reg(asd_pkg::CFG_RADIAL_MIN, asd_pkg::RADIAL_MIN_RESET);
		run_random(180);

		wait_drained();
		repeat (Drain) @(posedge clk);
		$display("%0d arm words sent over five threshold settings, %0d results checked,",
			sent, results_seen);
		$display("%0d of them valid directions; %0d mismatches", valid_seen, fails);
		if (fails == 0)
			$display("arm_swivel_direction_core regression: pass");
		else
			$display("arm_swivel_direction_core regression: fail");
		$finish;
	end

endmodule
